// ----- hdl/hpt_pkg.sv -----
`timescale 1ns / 1ps

package hpt_pkg;

    // Field widths and fixed-point formats
    localparam int COEF_W     = 48;
    localparam int COORD_W    = 32;
    localparam int INT_BITS   = 16;
    localparam int COEF_FRAC  = COEF_W - INT_BITS;
    localparam int COORD_FRAC = COORD_W - INT_BITS;
    localparam int NCOEF      = 9;
    localparam int IDX_W      = 4;

    // Coefficient split for the partial-product multipliers
    localparam int SPLIT  = COEF_W / 2;
    localparam int HI_W   = COEF_W - SPLIT;

    // Row dot product and divider widths
    localparam int PROD_W = COEF_W + COORD_W;
    localparam int ROW_W  = PROD_W + 2;
    localparam int QB     = COORD_W + 1;
    localparam int HEAD_W = ROW_W + COORD_FRAC - QB;

    // Back-end pipeline stages: magnitude, range check, QB quotient steps, clip
    localparam int DIV_LAT = QB + 3;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_XFORM = 1'b1;

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
    localparam logic signed [COEF_W-1:0] COEF_RESET [NCOEF] = '{
        COEF_ONE,  COEF_ZERO, COEF_ZERO,
        COEF_ZERO, COEF_ONE,  COEF_ZERO,
        COEF_ZERO, COEF_ZERO, COEF_ONE
    };

    typedef struct packed {
        logic signed [ROW_W-1:0]   nx;
        logic signed [ROW_W-1:0]   ny;
        logic signed [ROW_W-1:0]   w;
        logic        [COORD_W-1:0] angle;
    } t_rows;

endpackage

// ----- hdl/hpt_if.sv -----
`timescale 1ns / 1ps

interface hpt_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic        [hpt_pkg::IDX_W-1:0]       coef_index;
    logic signed [hpt_pkg::COEF_W-1:0]      coef_value;
    logic signed [hpt_pkg::COORD_W-1:0]     x_in;
    logic signed [hpt_pkg::COORD_W-1:0]     y_in;
    logic signed [hpt_pkg::COORD_W-1:0]     angle_in;

    modport source (output valid, func, coef_index, coef_value, x_in, y_in, angle_in,
                    input ready);
    modport sink   (input valid, func, coef_index, coef_value, x_in, y_in, angle_in,
                    output ready);
endinterface

interface hpt_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hpt_pkg::COORD_W-1:0]     x_out;
    logic signed [hpt_pkg::COORD_W-1:0]     y_out;
    logic signed [hpt_pkg::COORD_W-1:0]     angle_out;
    logic                                   saturated;

    modport source (output valid, x_out, y_out, angle_out, saturated, input ready);
    modport sink   (input valid, x_out, y_out, angle_out, saturated, output ready);
endinterface

// ----- hdl/hpt_front.sv -----
`timescale 1ns / 1ps

module hpt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hpt_in_if.sink         i_in,
    output hpt_pkg::t_rows o_rows,
    output logic           o_rows_valid,
    input  logic           i_rows_ready
);
    localparam int NPROD = 6;
    localparam int LO_PW = hpt_pkg::SPLIT + 1 + hpt_pkg::COORD_W;
    localparam int HI_PW = hpt_pkg::HI_W + hpt_pkg::COORD_W;

    logic signed [hpt_pkg::COEF_W-1:0]  r_coef [hpt_pkg::NCOEF];
    logic signed [hpt_pkg::COORD_W-1:0] w_var  [2];

    logic                               r_v1, r_v2, r_v3;
    logic signed [LO_PW-1:0]            r_plo  [NPROD];
    logic signed [HI_PW-1:0]            r_phi  [NPROD];
    logic signed [hpt_pkg::COEF_W-1:0]  r_c1   [3];
    logic        [hpt_pkg::COORD_W-1:0] r_ang1, r_ang2;
    logic signed [hpt_pkg::PROD_W-1:0]  r_term [NPROD];
    logic signed [hpt_pkg::PROD_W-1:0]  r_c2   [3];
    hpt_pkg::t_rows                     r_rows;

    logic w_en, w_acc, w_load, w_xform;

    assign w_en     = !r_v3 || i_rows_ready;
    assign i_in.ready = w_en;
    assign w_acc    = i_in.valid && w_en;
    assign w_load   = w_acc && (i_in.func == hpt_pkg::FUNC_LOAD);
    assign w_xform  = w_acc && (i_in.func == hpt_pkg::FUNC_XFORM);
    assign w_var[0] = i_in.x_in;
    assign w_var[1] = i_in.y_in;

    // coefficient store; out-of-range load index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hpt_pkg::NCOEF; i++) r_coef[i] <= hpt_pkg::COEF_RESET[i];
        end else if (w_load && (i_in.coef_index < hpt_pkg::IDX_W'(hpt_pkg::NCOEF))) begin
            r_coef[i_in.coef_index] <= i_in.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_xform;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: split partial products
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 2; c++) begin
                    r_plo[r*2+c] <= $signed({1'b0, r_coef[r*3+c][hpt_pkg::SPLIT-1:0]})
                                    * w_var[c];
                    r_phi[r*2+c] <= $signed(r_coef[r*3+c][hpt_pkg::COEF_W-1:hpt_pkg::SPLIT])
                                    * w_var[c];
                end
                r_c1[r] <= r_coef[r*3+2];
            end
            r_ang1 <= i_in.angle_in;
            // stage 2: full products, offsets aligned to product scale
            for (int k = 0; k < NPROD; k++) begin
                r_term[k] <= (hpt_pkg::PROD_W'(r_phi[k]) <<< hpt_pkg::SPLIT)
                             + hpt_pkg::PROD_W'(r_plo[k]);
            end
            for (int r = 0; r < 3; r++) begin
                r_c2[r] <= hpt_pkg::PROD_W'(r_c1[r]) <<< hpt_pkg::COORD_FRAC;
            end
            r_ang2 <= r_ang1;
            // stage 3: row sums
            r_rows.nx <= hpt_pkg::ROW_W'(r_term[0]) + hpt_pkg::ROW_W'(r_term[1])
                         + hpt_pkg::ROW_W'(r_c2[0]);
            r_rows.ny <= hpt_pkg::ROW_W'(r_term[2]) + hpt_pkg::ROW_W'(r_term[3])
                         + hpt_pkg::ROW_W'(r_c2[1]);
            r_rows.w  <= hpt_pkg::ROW_W'(r_term[4]) + hpt_pkg::ROW_W'(r_term[5])
                         + hpt_pkg::ROW_W'(r_c2[2]);
            r_rows.angle <= r_ang2;
        end
    end

    assign o_rows       = r_rows;
    assign o_rows_valid = r_v3;

endmodule

// ----- hdl/hpt_queue.sv -----
`timescale 1ns / 1ps

module hpt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hpt_pkg::t_rows i_data,
    input  logic           i_valid,
    output logic           o_ready,
    output hpt_pkg::t_rows o_data,
    output logic           o_valid,
    input  logic           i_pop
);
    hpt_pkg::t_rows              r_mem [hpt_pkg::QDEPTH];
    logic [hpt_pkg::QPTR_W-1:0]  r_wp, r_rp;
    logic [hpt_pkg::QPTR_W:0]    r_cnt;
    logic                        w_push, w_pop;

    assign o_ready = (r_cnt != (hpt_pkg::QPTR_W+1)'(hpt_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ----- hdl/hpt_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider: num * 2^COORD_FRAC / den, truncated toward
// zero and clipped to the coordinate range. One quotient bit per stage.
module hpt_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [hpt_pkg::ROW_W-1:0]   i_num,
    input  logic signed [hpt_pkg::ROW_W-1:0]   i_den,
    output logic signed [hpt_pkg::COORD_W-1:0] o_val,
    output logic                               o_sat
);
    localparam int RW  = hpt_pkg::ROW_W;
    localparam int QB  = hpt_pkg::QB;
    localparam int CW  = hpt_pkg::COORD_W;
    localparam int DW  = RW + hpt_pkg::COORD_FRAC;

    localparam logic [QB-1:0] Q_MAX = {2'b00, {(CW-1){1'b1}}};
    localparam logic [QB-1:0] Q_LIM = {2'b01, {(CW-1){1'b0}}};

    logic [RW-1:0]  r_mn, r_md;
    logic           r_neg;

    logic [RW-1:0]  r_rem [QB+1];
    logic [QB-1:0]  r_low [QB+1];
    logic [QB-1:0]  r_q   [QB+1];
    logic [RW-1:0]  r_mds [QB+1];
    logic           r_ngs [QB+1];
    logic           r_big [QB+1];

    logic [DW-1:0]  w_dvd;
    logic [RW-1:0]  w_head;
    logic [RW:0]    w_try  [QB];
    logic           w_ge   [QB];
    logic [RW-1:0]  w_nrem [QB];
    logic [QB-1:0]  w_negq;
    logic           w_satp, w_satn;

    logic signed [CW-1:0] r_val;
    logic                 r_sat;

    assign w_dvd  = {r_mn, {hpt_pkg::COORD_FRAC{1'b0}}};
    assign w_head = RW'(w_dvd[DW-1:QB]);

    always_comb begin
        for (int i = 0; i < QB; i++) begin
            w_try[i]  = {r_rem[i], r_low[i][QB-1]};
            w_ge[i]   = (w_try[i] >= {1'b0, r_mds[i]});
            w_nrem[i] = w_ge[i] ? RW'(w_try[i] - {1'b0, r_mds[i]}) : w_try[i][RW-1:0];
        end
    end

    assign w_negq = '0 - r_q[QB];
    assign w_satp = r_big[QB] || (r_q[QB] > Q_MAX);
    assign w_satn = r_big[QB] || (r_q[QB] > Q_LIM);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // magnitudes and result sign
            r_mn  <= i_num[RW-1] ? RW'(-i_num) : RW'(i_num);
            r_md  <= i_den[RW-1] ? RW'(-i_den) : RW'(i_den);
            r_neg <= i_num[RW-1] ^ i_den[RW-1];
            // quotient needs more than QB bits when head >= divisor
            r_rem[0] <= w_head;
            r_low[0] <= w_dvd[QB-1:0];
            r_q[0]   <= '0;
            r_mds[0] <= r_md;
            r_ngs[0] <= r_neg;
            r_big[0] <= (w_head >= r_md);
            for (int i = 0; i < QB; i++) begin
                r_rem[i+1] <= w_nrem[i];
                r_low[i+1] <= r_low[i] << 1;
                r_q[i+1]   <= {r_q[i][QB-2:0], w_ge[i]};
                r_mds[i+1] <= r_mds[i];
                r_ngs[i+1] <= r_ngs[i];
                r_big[i+1] <= r_big[i];
            end
            // clip
            if (r_ngs[QB]) begin
                r_sat <= w_satn;
                r_val <= w_satn ? {1'b1, {(CW-1){1'b0}}} : w_negq[CW-1:0];
            end else begin
                r_sat <= w_satp;
                r_val <= w_satp ? {1'b0, {(CW-1){1'b1}}} : r_q[QB][CW-1:0];
            end
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule

// ----- hdl/hpt_back.sv -----
`timescale 1ns / 1ps

module hpt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hpt_pkg::t_rows i_rows,
    input  logic           i_rows_valid,
    output logic           o_pop,
    hpt_out_if.source      o_out
);
    localparam int LAT = hpt_pkg::DIV_LAT;

    logic                                r_vld [LAT];
    logic        [hpt_pkg::COORD_W-1:0]  r_ang [LAT];
    logic                                w_en;
    logic signed [hpt_pkg::ROW_W-1:0]    w_den;
    logic signed [hpt_pkg::COORD_W-1:0]  w_xq, w_yq;
    logic                                w_xs, w_ys;

    assign w_en  = !r_vld[LAT-1] || o_out.ready;
    assign o_pop = w_en && i_rows_valid;
    // a zero denominator is taken as one LSB
    assign w_den = (i_rows.w == '0) ? hpt_pkg::ROW_W'(1) : i_rows.w;

    hpt_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (i_rows.nx),
        .i_den (w_den),
        .o_val (w_xq),
        .o_sat (w_xs)
    );

    hpt_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (i_rows.ny),
        .i_den (w_den),
        .o_val (w_yq),
        .o_sat (w_ys)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_rows_valid;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang[0] <= i_rows.angle;
            for (int i = 1; i < LAT; i++) r_ang[i] <= r_ang[i-1];
        end
    end

    assign o_out.valid     = r_vld[LAT-1];
    assign o_out.x_out     = w_xq;
    assign o_out.y_out     = w_yq;
    assign o_out.angle_out = r_ang[LAT-1];
    assign o_out.saturated = w_xs | w_ys;

endmodule

// ----- hdl/homography_point_transform.sv -----
`timescale 1ns / 1ps

// Planar homography point transform. Holds a 3x3 matrix of signed Q16.32
// coefficients (row-major, identity after reset) and maps Q16.16 points
// through it with a perspective divide: x' = (m00 x + m01 y + m02) / w,
// y' = (m10 x + m11 y + m12) / w, w = m20 x + m21 y + m22, quotients
// truncated toward zero and clipped to Q16.16 with the saturated flag set.
// A zero w is taken as +1 LSB. The angle rides along unchanged. A load
// transfer (func = 0) writes one coefficient and gives no result; an
// index above 8 is ignored. Loads and transforms may be interleaved
// freely: each transform uses the matrix as it stood when it was
// accepted. Throughput is one transfer per cycle in either direction
// while the output is not stalled. A transform passes the front's
// partial-product, full-product and row-sum stages, the 4-entry queue
// and the back (magnitude, range check, one stage per quotient bit of
// the 33-step divider, clip); output stalls back up through the queue.
module homography_point_transform (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hpt_in_if.sink    i_in,
    hpt_out_if.source o_out
);
    hpt_pkg::t_rows w_f_rows, w_q_rows;
    logic           w_f_valid, w_f_ready;
    logic           w_q_valid, w_q_pop;

    // front: coefficient store, products and row sums
    hpt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_rows       (w_f_rows),
        .o_rows_valid (w_f_valid),
        .i_rows_ready (w_f_ready)
    );

    // decouples the front from back-end stalls
    hpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_f_rows),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .o_data  (w_q_rows),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop)
    );

    // back: two dividers sharing the denominator, output register at the end
    hpt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rows       (w_q_rows),
        .i_rows_valid (w_q_valid),
        .o_pop        (w_q_pop),
        .o_out        (o_out)
    );

endmodule

// ----- hdl/hpt_checker.sv -----
`timescale 1ns / 1ps

module hpt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               i_ready,
    input logic signed [hpt_pkg::COORD_W-1:0] i_x,
    input logic signed [hpt_pkg::COORD_W-1:0] i_y,
    input logic signed [hpt_pkg::COORD_W-1:0] i_angle,
    input logic                               i_sat
);
    localparam logic [hpt_pkg::COORD_W-1:0] C_MAX = {1'b0, {(hpt_pkg::COORD_W-1){1'b1}}};
    localparam logic [hpt_pkg::COORD_W-1:0] C_MIN = {1'b1, {(hpt_pkg::COORD_W-1){1'b0}}};

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_sat |-> (i_x == C_MAX || i_x == C_MIN || i_y == C_MAX || i_y == C_MIN))
        else $error("saturated flag without a clipped coordinate");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_x) && $stable(i_y) && $stable(i_angle)
                               && $stable(i_sat))
        else $error("result changed while stalled");

endmodule

bind homography_point_transform hpt_checker u_hpt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_x     (o_out.x_out),
    .i_y     (o_out.y_out),
    .i_angle (o_out.angle_out),
    .i_sat   (o_out.saturated)
);

// ----- sim/hpt_scoreboard.sv -----
`timescale 1ns / 1ps

module hpt_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    hpt_in_if    i_in,
    hpt_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);
    typedef struct {
        logic signed [hpt_pkg::COORD_W-1:0] x;
        logic signed [hpt_pkg::COORD_W-1:0] y;
        logic signed [hpt_pkg::COORD_W-1:0] angle;
        logic                               sat;
    } t_point;

    logic signed [hpt_pkg::COEF_W-1:0] matrix [hpt_pkg::NCOEF];
    t_point                            points_due [$];

    // row r of the matrix applied to (x, y, 1), exact
    function automatic logic signed [127:0] row_sum(int r, logic signed [127:0] xs,
                                                    logic signed [127:0] ys);
        logic signed [127:0] a, b, c;
        a = 128'(matrix[r*3]);
        b = 128'(matrix[r*3+1]);
        c = 128'(matrix[r*3+2]);
        return a * xs + b * ys + (c <<< hpt_pkg::COORD_FRAC);
    endfunction

    // n / d in coordinate format, truncated toward zero, clipped
    function automatic logic [hpt_pkg::COORD_W-1:0] div_clip(logic signed [127:0] n,
                                                             logic signed [127:0] d,
                                                             inout logic sat);
        logic        neg;
        logic [127:0] mn, md, mq;
        neg = n[127] ^ d[127];
        mn  = n[127] ? -n : n;
        md  = d[127] ? -d : d;
        mq  = (mn << hpt_pkg::COORD_FRAC) / md;
        if (!neg) begin
            if (mq > 128'h7fff_ffff) begin
                sat = 1'b1;
                return 32'h7fff_ffff;
            end
            return mq[hpt_pkg::COORD_W-1:0];
        end
        if (mq > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -mq[hpt_pkg::COORD_W-1:0];
    endfunction

    function automatic t_point map_point(logic signed [hpt_pkg::COORD_W-1:0] x,
                                         logic signed [hpt_pkg::COORD_W-1:0] y,
                                         logic signed [hpt_pkg::COORD_W-1:0] angle);
        t_point              p;
        logic signed [127:0] xs, ys, w;
        logic                sat;
        xs  = 128'(x);
        ys  = 128'(y);
        sat = 1'b0;
        w   = row_sum(2, xs, ys);
        if (w == 0) w = 128'sd1;  // degenerate denominator -> +1 LSB
        p.x     = div_clip(row_sum(0, xs, ys), w, sat);
        p.y     = div_clip(row_sum(1, xs, ys), w, sat);
        p.angle = angle;
        p.sat   = sat;
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [hpt_pkg::COORD_W-1:0] got,
                                   logic [hpt_pkg::COORD_W-1:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_point p;
        if (!i_rst_n) begin
            for (int i = 0; i < hpt_pkg::NCOEF; i++) matrix[i] = hpt_pkg::COEF_RESET[i];
            points_due.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (i_in.func == hpt_pkg::FUNC_LOAD) begin
                    if (i_in.coef_index < hpt_pkg::NCOEF)
                        matrix[i_in.coef_index] = i_in.coef_value;
                end else begin
                    points_due.push_back(map_point(i_in.x_in, i_in.y_in, i_in.angle_in));
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (points_due.size() == 0) begin
                    report_mismatch("unexpected result", i_out.x_out, '0);
                end else begin
                    p = points_due.pop_front();
                    if (i_out.x_out !== p.x) report_mismatch("x_out", i_out.x_out, p.x);
                    if (i_out.y_out !== p.y) report_mismatch("y_out", i_out.y_out, p.y);
                    if (i_out.angle_out !== p.angle)
                        report_mismatch("angle_out", i_out.angle_out, p.angle);
                    if (i_out.saturated !== p.sat)
                        report_mismatch("saturated", hpt_pkg::COORD_W'(i_out.saturated),
                                        hpt_pkg::COORD_W'(p.sat));
                end
            end
        end
        o_pending = points_due.size();
    end
endmodule

// ----- sim/tb_homography_point_transform.sv -----
`timescale 1ns / 1ps

module tb_homography_point_transform;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   send_idle_pct, recv_idle_pct;

    hpt_in_if  in_ch ();
    hpt_out_if out_ch ();

    homography_point_transform uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    hpt_scoreboard scoreboard (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch),
        .i_out    (out_ch),
        .o_errors (errors),
        .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.func       = hpt_pkg::FUNC_LOAD;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.x_in       = '0;
        in_ch.y_in       = '0;
        in_ch.angle_in   = '0;
        out_ch.ready     = 1'b0;
    end

    // receiver side: random backpressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one transfer on the input channel, with random idle cycles ahead of it
    task automatic send(logic func, logic [hpt_pkg::IDX_W-1:0] idx,
                        logic signed [hpt_pkg::COEF_W-1:0] cv,
                        logic signed [hpt_pkg::COORD_W-1:0] x,
                        logic signed [hpt_pkg::COORD_W-1:0] y,
                        logic signed [hpt_pkg::COORD_W-1:0] ang);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= func;
        in_ch.coef_index <= idx;
        in_ch.coef_value <= cv;
        in_ch.x_in       <= x;
        in_ch.y_in       <= y;
        in_ch.angle_in   <= ang;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic load(int idx, logic signed [hpt_pkg::COEF_W-1:0] cv);
        send(hpt_pkg::FUNC_LOAD, hpt_pkg::IDX_W'(idx), cv, $urandom, $urandom, $urandom);
    endtask

    task automatic xform(logic signed [hpt_pkg::COORD_W-1:0] x,
                         logic signed [hpt_pkg::COORD_W-1:0] y,
                         logic signed [hpt_pkg::COORD_W-1:0] ang);
        send(hpt_pkg::FUNC_XFORM, hpt_pkg::IDX_W'($urandom),
             hpt_pkg::COEF_W'({$urandom, $urandom}), x, y, ang);
    endtask

    // wait until every expected result has come, then realign to the rising edge
    task automatic drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        while (pending != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        @(posedge i_clk);
    endtask

    // coefficient value shaped by position so most matrices stay well-conditioned
    function automatic logic signed [hpt_pkg::COEF_W-1:0] pick_coef(int idx);
        logic signed [hpt_pkg::COEF_W-1:0] v;
        int                                mode;
        mode = $urandom_range(9);
        v    = hpt_pkg::COEF_W'({$urandom, $urandom});
        if (mode == 0) return v;                             // anything
        if (mode == 1) return (mode & 1) ? hpt_pkg::COEF_ZERO : v;
        if (mode == 2) return $urandom_range(1) ? {1'b0, {(hpt_pkg::COEF_W-1){1'b1}}}
                                                : {1'b1, {(hpt_pkg::COEF_W-1){1'b0}}};
        if (idx == 6 || idx == 7) return v >>> 26;           // mild perspective
        if (idx == 8) return hpt_pkg::COEF_ONE + (v >>> 16);
        return v >>> 13;                                     // about +-4.0
    endfunction

    function automatic logic signed [hpt_pkg::COORD_W-1:0] pick_coord();
        logic signed [hpt_pkg::COORD_W-1:0] v;
        v = $urandom;
        return ($urandom_range(4) == 0) ? v : (v >>> 6);
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                int idx;
                idx = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8);
                load(idx, pick_coef(idx));
            end else begin
                xform(pick_coord(), pick_coord(), $urandom);
            end
        end
    endtask

    initial begin
        send_idle_pct = 9;
        recv_idle_pct = 61;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity after reset: coordinate and angle extremes
        xform(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        xform(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        xform(32'sh0001_0000, -32'sh0002_8000, 32'sh0);
        // indices past the end are dropped
        load(9, hpt_pkg::COEF_W'({$urandom, $urandom}));
        load(15, hpt_pkg::COEF_ZERO);
        xform(32'sh0010_0000, 32'sh0020_0000, 32'sh1234);
        // scaled w
        load(8, hpt_pkg::COEF_ONE <<< 1);
        xform(32'sh0003_0001, -32'sh0005_0003, 32'sh1);
        load(8, -hpt_pkg::COEF_ONE);
        xform(32'sh0003_0001, 32'sh0005_0003, 32'sh2);
        // zero denominator: zero numerator, then a clipping one
        load(8, hpt_pkg::COEF_ZERO);
        xform(32'sh0, 32'sh0, 32'sh3);
        xform(32'sh0000_0001, -32'sh0000_0001, 32'sh4);
        // coefficient extremes
        load(0, {1'b0, {(hpt_pkg::COEF_W-1){1'b1}}});
        load(4, {1'b1, {(hpt_pkg::COEF_W-1){1'b0}}});
        load(6, 48'sh1);
        load(7, -48'sh1);
        load(8, hpt_pkg::COEF_ONE);
        xform(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh5);
        xform(32'sh0000_0100, 32'sh8000_0000, 32'sh6);
        for (int i = 0; i < hpt_pkg::NCOEF; i++) load(i, hpt_pkg::COEF_RESET[i]);

        random_phase(210);

        // drain everything before going on
        in_ch.valid <= 1'b0;
        drain();

        send_idle_pct = 61;
        recv_idle_pct = 9;
        random_phase(210);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(210);

        in_ch.valid <= 1'b0;
        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/hpt_pkg.sv
hdl/hpt_if.sv
hdl/hpt_front.sv
hdl/hpt_queue.sv
hdl/hpt_div.sv
hdl/hpt_back.sv
hdl/homography_point_transform.sv
hdl/hpt_checker.sv
sim/hpt_scoreboard.sv
sim/tb_homography_point_transform.sv
